// ----- rtl/mbfc_pkg.sv -----
`default_nettype none

package mbfc_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] fmt_t;

    localparam int SIG_COUNT = 12;
    localparam int SIG_MAX   = 8;
    localparam int TAR_AT    = 257;
    localparam int TAR_LEN   = 5;
    localparam int TAR_MIN   = 262;
    localparam int TEXT_SCALE = 100;

    localparam logic [6:0] THRESHOLD_RESET = 7'd90;

    localparam fmt_t FMT_EMPTY  = 4'd0;
    localparam fmt_t FMT_ELF    = 4'd1;
    localparam fmt_t FMT_PSF1   = 4'd2;
    localparam fmt_t FMT_PSF2   = 4'd3;
    localparam fmt_t FMT_PNG    = 4'd4;
    localparam fmt_t FMT_JPEG   = 4'd5;
    localparam fmt_t FMT_BMP    = 4'd6;
    localparam fmt_t FMT_GIF    = 4'd7;
    localparam fmt_t FMT_PDF    = 4'd8;
    localparam fmt_t FMT_ZIP    = 4'd9;
    localparam fmt_t FMT_TAR    = 4'd10;
    localparam fmt_t FMT_TEXT   = 4'd11;
    localparam fmt_t FMT_BINARY = 4'd12;

    // signature bytes, unused tail positions padded with zero
    localparam byte_t SIG_BYTES [SIG_COUNT][SIG_MAX] = '{
        '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h36, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'hB5, 8'h4A, 8'h86, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
        '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h37, 8'h61, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'h00, 8'h00},
        '{8'h25, 8'h50, 8'h44, 8'h46, 8'h2D, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h05, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4B, 8'h07, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
        4'd4, 4'd2, 4'd4, 4'd8, 4'd3, 4'd2, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd4
    };

    localparam fmt_t SIG_CODE [SIG_COUNT] = '{
        FMT_ELF, FMT_PSF1, FMT_PSF2, FMT_PNG, FMT_JPEG, FMT_BMP,
        FMT_GIF, FMT_GIF, FMT_PDF, FMT_ZIP, FMT_ZIP, FMT_ZIP
    };

    localparam byte_t TAR_BYTES [TAR_LEN] = '{8'h75, 8'h73, 8'h74, 8'h61, 8'h72};

    // per-file flags handed from front to back with each finished file
    typedef struct packed {
        logic [SIG_COUNT-1:0] sig;
        logic                 tar;
        logic                 zero;
    } rec_flags_t;

    function automatic logic is_printable(input byte_t b);
        return (b == 8'd9) || (b == 8'd10) || (b == 8'd13) ||
               ((b >= 8'd32) && (b <= 8'd126));
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mbfc_fifo.sv -----
`default_nettype none

module mbfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mbfc_front.sv -----
`default_nettype none

module mbfc_front
    import mbfc_pkg::*;
#(
    parameter int PROBE_BYTES = 512,
    parameter int POS_W = $clog2(PROBE_BYTES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire byte_t            byte_value,
    input  wire logic             carries_byte,
    input  wire logic             last,
    output logic                  rec_push,
    output rec_flags_t            rec_flags,
    output logic [POS_W-1:0]      rec_size,
    output logic [POS_W-1:0]      rec_printable
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] prn_reg, prn_next;
    rec_flags_t       flags_reg, flags_next;
    logic [31:0]      pos_ext;
    logic [2:0]       tar_idx;
    logic             take;

    assign pos_ext = 32'(pos_reg);
    assign tar_idx = 3'(pos_ext - 32'(TAR_AT));
    assign take    = carries_byte && (pos_ext < 32'(PROBE_BYTES));

    // state after this item's byte, if any
    always_comb
    begin
        pos_next   = pos_reg;
        prn_next   = prn_reg;
        flags_next = flags_reg;
        if (take)
        begin
            for (int s = 0; s < SIG_COUNT; s++)
            begin
                if ((pos_ext < 32'(SIG_LEN[s])) &&
                    (SIG_BYTES[s][pos_reg[2:0]] != byte_value))
                begin
                    flags_next.sig[s] = 1'b0;
                end
            end
            if ((pos_ext >= 32'(TAR_AT)) && (pos_ext < 32'(TAR_AT + TAR_LEN)) &&
                (TAR_BYTES[tar_idx] != byte_value))
            begin
                flags_next.tar = 1'b0;
            end
            if (byte_value == 8'd0)
            begin
                flags_next.zero = 1'b1;
            end
            if (is_printable(byte_value))
            begin
                prn_next = prn_reg + 1'b1;
            end
            pos_next = pos_reg + 1'b1;
        end
    end

    assign rec_push      = accept && last;
    assign rec_flags     = flags_next;
    assign rec_size      = pos_next;
    assign rec_printable = prn_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            prn_reg   <= '0;
            flags_reg <= '{sig: '1, tar: 1'b1, zero: 1'b0};
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                prn_reg   <= '0;
                flags_reg <= '{sig: '1, tar: 1'b1, zero: 1'b0};
            end
            else
            begin
                pos_reg   <= pos_next;
                prn_reg   <= prn_next;
                flags_reg <= flags_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mbfc_back.sv -----
`default_nettype none

module mbfc_back
    import mbfc_pkg::*;
#(
    parameter int PROBE_BYTES = 512,
    parameter int POS_W = $clog2(PROBE_BYTES + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [6:0]       threshold,
    input  wire logic             rec_empty,
    output logic                  rec_pop,
    input  wire rec_flags_t       rec_flags,
    input  wire logic [POS_W-1:0] rec_size,
    input  wire logic [POS_W-1:0] rec_printable,
    output logic                  empty,
    input  wire logic             pop,
    output fmt_t                  format_code,
    output logic [9:0]            bytes_examined
);

    localparam int PROD_W = POS_W + 7;
    localparam int RES_W  = $bits(fmt_t) + 10;

    logic [31:0]          size_ext;
    logic [PROD_W-1:0]    prn_scaled;
    logic [PROD_W-1:0]    size_scaled;
    logic                 sig_hit;
    fmt_t                 sig_fmt;
    fmt_t                 code;
    logic                 res_full;
    logic [RES_W-1:0]     res_out;

    assign size_ext    = 32'(rec_size);
    assign prn_scaled  = PROD_W'(rec_printable) * PROD_W'(TEXT_SCALE);
    assign size_scaled = PROD_W'(threshold) * PROD_W'(rec_size);

    // lowest matching signature wins
    always_comb
    begin
        sig_hit = 1'b0;
        sig_fmt = FMT_BINARY;
        for (int s = SIG_COUNT - 1; s >= 0; s--)
        begin
            if (rec_flags.sig[s] && (size_ext >= 32'(SIG_LEN[s])))
            begin
                sig_hit = 1'b1;
                sig_fmt = SIG_CODE[s];
            end
        end
    end

    always_comb
    begin
        priority if (rec_size == '0)
        begin
            code = FMT_EMPTY;
        end
        else if (sig_hit)
        begin
            code = sig_fmt;
        end
        else if ((size_ext >= 32'(TAR_MIN)) && rec_flags.tar)
        begin
            code = FMT_TAR;
        end
        else if (!rec_flags.zero && (prn_scaled >= size_scaled))
        begin
            code = FMT_TEXT;
        end
        else
        begin
            code = FMT_BINARY;
        end
    end

    assign rec_pop = !rec_empty && !res_full;

    mbfc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_pop),
        .din   ({code, 10'(rec_size)}),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign format_code    = res_out[RES_W-1:10];
    assign bytes_examined = res_out[9:0];

endmodule

`default_nettype wire

// ----- rtl/magic_byte_format_classifier_unit.sv -----
`default_nettype none

// Magic-byte file format classifier. Feed the leading bytes of a file, one
// byte per transfer from offset zero, with last set on the final transfer of
// the file (an empty file is a single transfer with carries_byte low and last
// high). One result transfer per file follows: format_code (0 empty, 1 ELF,
// 2 PSF1, 3 PSF2, 4 PNG, 5 JPEG, 6 BMP, 7 GIF, 8 PDF, 9 ZIP, 10 TAR, 11 text,
// 12 binary) and bytes_examined, the bytes used, capped at PROBE_BYTES.
// Bytes beyond PROBE_BYTES are accepted and ignored. The unit takes one byte
// every clock cycle while full is low, including back-to-back files; a result
// is registered in the record queue and then in the result queue before it
// reaches the outputs. full rises only when two finished files wait for the
// classification stage, which in turn backs up only when two results sit
// unread in the output queue. The text threshold (percent, reset 90) is
// written through cfg_we/cfg_wdata and should only change between files with
// no results outstanding.
module magic_byte_format_classifier_unit
    import mbfc_pkg::*;
#(
    parameter int PROBE_BYTES = 512
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte stream in
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] byte_value,
    input  wire logic       carries_byte,
    input  wire logic       last,
    // results out
    output logic            empty,
    input  wire logic       pop,
    output logic [3:0]      format_code,
    output logic [9:0]      bytes_examined,
    // threshold register
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);

    localparam int POS_W = $clog2(PROBE_BYTES + 1);
    localparam int REC_W = $bits(rec_flags_t) + 2 * POS_W;

    logic [6:0]       threshold_reg;
    logic             accept;

    // front -> record queue
    logic             rec_push;
    rec_flags_t       rec_flags_in;
    logic [POS_W-1:0] rec_size_in;
    logic [POS_W-1:0] rec_prn_in;

    // record queue -> back
    logic             rec_pop;
    logic             rec_empty;
    logic [REC_W-1:0] rec_out;
    rec_flags_t       rec_flags_out;
    logic [POS_W-1:0] rec_size_out;
    logic [POS_W-1:0] rec_prn_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // every non-final byte is absorbed by the front; only a final transfer
    // needs a free record slot, but full is kept independent of payload
    assign accept = push && !full;

    // front: tracks position, signature prefixes, ustar, zero bytes, printable count
    mbfc_front #(
        .PROBE_BYTES (PROBE_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_value    (byte_value),
        .carries_byte  (carries_byte),
        .last          (last),
        .rec_push      (rec_push),
        .rec_flags     (rec_flags_in),
        .rec_size      (rec_size_in),
        .rec_printable (rec_prn_in)
    );

    // short record queue decoupling front and back
    mbfc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_rec_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rec_push),
        .din   ({rec_flags_in, rec_size_in, rec_prn_in}),
        .full  (full),
        .pop   (rec_pop),
        .dout  (rec_out),
        .empty (rec_empty)
    );

    assign rec_flags_out = rec_out[REC_W-1:2*POS_W];
    assign rec_size_out  = rec_out[2*POS_W-1:POS_W];
    assign rec_prn_out   = rec_out[POS_W-1:0];

    // back: priority decode and text ratio test, into the result queue
    mbfc_back #(
        .PROBE_BYTES (PROBE_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .threshold      (threshold_reg),
        .rec_empty      (rec_empty),
        .rec_pop        (rec_pop),
        .rec_flags      (rec_flags_out),
        .rec_size       (rec_size_out),
        .rec_printable  (rec_prn_out),
        .empty          (empty),
        .pop            (pop),
        .format_code    (format_code),
        .bytes_examined (bytes_examined)
    );

endmodule

`default_nettype wire
